// ----- hw/rtl/tccs_pkg.sv -----
package tccs_pkg;

    localparam int OP_W   = 2;
    localparam int BYTE_W = 8;
    localparam int CELL_W = 16;
    localparam int COL_PW = 7;
    localparam int ROW_PW = 5;

    localparam logic [BYTE_W-1:0] NEWLINE_CODE    = 8'd10;
    localparam logic [BYTE_W-1:0] BLANK_ATTRIBUTE = 8'h07;

    typedef enum logic [OP_W-1:0] {
        OP_PUT,
        OP_WRITE,
        OP_CURSOR,
        OP_READ
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SCROLL,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic commit;
        logic scroll;
        logic finish_read;
        logic finish_scroll;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_read;
        logic need_scroll;
        logic sweep_done;
    } dp_status_t;

endpackage

// ----- hw/rtl/tccs_ctrl.sv -----
module tccs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  tccs_pkg::dp_status_t  status,
    output tccs_pkg::ctrl_cmd_t   cmd,
    output logic                  busy
);
    import tccs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.sweep_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.is_read)
                begin
                    state_next = ST_READ;
                end
                else if (status.need_scroll)
                begin
                    state_next = ST_SCROLL;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            ST_SCROLL:
            begin
                if (status.sweep_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd               = '0;
        busy              = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            ST_EXEC:
            begin
                cmd.commit = !status.is_read && !status.need_scroll;
                cmd.scroll = !status.is_read && status.need_scroll;
            end
            ST_READ:
            begin
                cmd.finish_read = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish_scroll = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/tccs_dp.sv -----
module tccs_dp #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tccs_pkg::ctrl_cmd_t           cmd,
    output tccs_pkg::dp_status_t          status,
    input  logic [tccs_pkg::OP_W-1:0]     operation,
    input  logic [tccs_pkg::BYTE_W-1:0]   char_code,
    input  logic [tccs_pkg::BYTE_W-1:0]   attribute,
    input  logic [tccs_pkg::COL_PW-1:0]   column,
    input  logic [tccs_pkg::ROW_PW-1:0]   row,
    output logic                          done,
    output logic [tccs_pkg::BYTE_W-1:0]   cell_char,
    output logic [tccs_pkg::BYTE_W-1:0]   cell_attribute,
    output logic [tccs_pkg::COL_PW-1:0]   cursor_column,
    output logic [tccs_pkg::ROW_PW-1:0]   cursor_row
);
    import tccs_pkg::*;

    localparam int CELLS       = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int COPY_CELLS  = CELLS - SCREEN_COLUMNS;
    localparam int ADDR_W      = $clog2(CELLS);
    localparam int COL_W       = $clog2(SCREEN_COLUMNS + 1);
    localparam int ROW_W       = $clog2(SCREEN_ROWS);

    logic [CELL_W-1:0] mem [CELLS];

    // latched transaction
    op_t               op_q;
    logic [BYTE_W-1:0] char_q;
    logic [BYTE_W-1:0] attr_q;
    logic [COL_PW-1:0] col_q;
    logic [ROW_PW-1:0] row_q;

    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  line_reg;
    logic [ROW_W-1:0]  line_next;

    // sweep engine (reset clear and scroll copy)
    logic              sweep_on_reg;
    logic              sweep_clear_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic              pipe_valid_reg;
    logic [ADDR_W-1:0] pipe_addr_reg;
    logic              pipe_copy_reg;
    logic [CELL_W-1:0] pipe_fill_reg;
    logic [CELL_W-1:0] rd_data_reg;

    logic              done_reg;
    logic [BYTE_W-1:0] cell_char_reg;
    logic [BYTE_W-1:0] cell_attr_reg;

    logic              newline;
    logic              wrap;
    logic              in_grid;
    logic              need_scroll;
    logic [ROW_W-1:0]  line_eff;
    logic [COL_W-1:0]  col_eff;
    logic [ADDR_W-1:0] put_addr;
    logic [ADDR_W-1:0] op_addr;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [COL_W-1:0]  col_sat;
    logic [ROW_W-1:0]  row_sat;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              result_load;
    int                line_sum;

    always_comb
    begin
        newline  = (char_q == NEWLINE_CODE);
        wrap     = (int'(col_reg) == SCREEN_COLUMNS);
        in_grid  = (int'(col_q) < SCREEN_COLUMNS) && (int'(row_q) < SCREEN_ROWS);
        line_sum = int'(line_reg) + int'(wrap) + int'(newline);
        need_scroll = (op_q == OP_PUT) && (line_sum >= SCREEN_ROWS);
        line_eff = ROW_W'(line_sum);
        col_eff  = (wrap || newline) ? '0 : col_reg;
        put_addr = ADDR_W'(int'(line_eff) * SCREEN_COLUMNS + int'(col_eff));
        op_addr  = ADDR_W'(int'(row_q) * SCREEN_COLUMNS + int'(col_q));
        src_addr = ADDR_W'(int'(idx_reg) + SCREEN_COLUMNS);
        rd_addr  = sweep_on_reg ? src_addr : op_addr;
        col_sat  = (int'(col_q) < SCREEN_COLUMNS) ? COL_W'(col_q)
                                                  : COL_W'(SCREEN_COLUMNS - 1);
        row_sat  = (int'(row_q) < SCREEN_ROWS) ? ROW_W'(row_q)
                                               : ROW_W'(SCREEN_ROWS - 1);
    end

    assign status.is_read     = (op_q == OP_READ);
    assign status.need_scroll = need_scroll;
    assign status.sweep_done  = pipe_valid_reg && (pipe_addr_reg == ADDR_W'(CELLS - 1));

    always_comb
    begin
        wr_en     = 1'b0;
        wr_addr   = put_addr;
        wr_data   = {attr_q, char_q};
        col_next  = col_reg;
        line_next = line_reg;
        if (cmd.commit)
        begin
            case (op_q)
                OP_PUT:
                begin
                    wr_en     = !newline;
                    line_next = line_eff;
                    col_next  = newline ? '0 : COL_W'(int'(col_eff) + 1);
                end
                OP_WRITE:
                begin
                    wr_en   = in_grid;
                    wr_addr = op_addr;
                end
                OP_CURSOR:
                begin
                    col_next  = col_sat;
                    line_next = row_sat;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
        else if (cmd.scroll)
        begin
            col_next  = '0;
            line_next = ROW_W'(SCREEN_ROWS - 1);
        end
        else if (cmd.finish_scroll)
        begin
            // cursor sits at column 0 of the bottom row here
            wr_en    = !newline;
            col_next = newline ? col_reg : COL_W'(int'(col_reg) + 1);
        end
    end

    assign result_load = cmd.commit || cmd.finish_read || cmd.finish_scroll;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            line_reg        <= '0;
            sweep_on_reg    <= 1'b1;
            sweep_clear_reg <= 1'b1;
            idx_reg         <= '0;
            pipe_valid_reg  <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            col_reg        <= col_next;
            line_reg       <= line_next;
            done_reg       <= result_load;
            pipe_valid_reg <= sweep_on_reg;
            if (cmd.scroll)
            begin
                sweep_on_reg    <= 1'b1;
                sweep_clear_reg <= 1'b0;
                idx_reg         <= '0;
            end
            else if (sweep_on_reg)
            begin
                idx_reg <= ADDR_W'(int'(idx_reg) + 1);
                if (idx_reg == ADDR_W'(CELLS - 1))
                begin
                    sweep_on_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_q   <= op_t'(operation);
            char_q <= char_code;
            attr_q <= attribute;
            col_q  <= column;
            row_q  <= row;
        end
        pipe_addr_reg <= idx_reg;
        pipe_copy_reg <= !sweep_clear_reg && (int'(idx_reg) < COPY_CELLS);
        pipe_fill_reg <= sweep_clear_reg ? '0 : {BLANK_ATTRIBUTE, 8'h00};
        if (result_load)
        begin
            if (cmd.finish_read && in_grid)
            begin
                cell_char_reg <= rd_data_reg[BYTE_W-1:0];
                cell_attr_reg <= rd_data_reg[CELL_W-1:BYTE_W];
            end
            else
            begin
                cell_char_reg <= '0;
                cell_attr_reg <= '0;
            end
        end
    end

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (pipe_valid_reg)
        begin
            mem[pipe_addr_reg] <= pipe_copy_reg ? rd_data_reg : pipe_fill_reg;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign done           = done_reg;
    assign cell_char      = cell_char_reg;
    assign cell_attribute = cell_attr_reg;
    assign cursor_column  = COL_PW'(col_reg);
    assign cursor_row     = ROW_PW'(line_reg);

endmodule

// ----- hw/rtl/text_console_cursor_scroll.sv -----
// Text console: a grid of SCREEN_COLUMNS x SCREEN_ROWS cells (character and
// attribute) in a single-port-write, registered-read RAM, plus a cursor.
// A transaction is taken at a clock edge with start high and busy low; the
// operation and its fields are sampled there. Each transaction returns one
// result on the result ports, valid for exactly one cycle while done is high.
// Steps after the accept edge:
//   put character, write cell, set cursor: done is registered from the commit
//     in EXEC; a new transaction can be taken while done is high.
//   read cell: EXEC reads the RAM into its read register, READ loads the result.
//   put character that scrolls: EXEC starts the RAM copy sweep, which moves one
//     cell per cycle over every cell; FINISH then writes the character.
// After reset the RAM is swept to zero, one cell per cycle, over every cell;
// busy stays high until it ends. The cursor resets to column 0, row 0. The
// receiver cannot stall: results are presented once and must be taken in
// that cycle.
module text_console_cursor_scroll #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tccs_pkg::OP_W-1:0]     operation,
    input  logic [tccs_pkg::BYTE_W-1:0]   char_code,
    input  logic [tccs_pkg::BYTE_W-1:0]   attribute,
    input  logic [tccs_pkg::COL_PW-1:0]   column,
    input  logic [tccs_pkg::ROW_PW-1:0]   row,
    output logic                          done,
    output logic [tccs_pkg::BYTE_W-1:0]   cell_char,
    output logic [tccs_pkg::BYTE_W-1:0]   cell_attribute,
    output logic [tccs_pkg::COL_PW-1:0]   cursor_column,
    output logic [tccs_pkg::ROW_PW-1:0]   cursor_row
);
    import tccs_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    tccs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    tccs_dp #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .operation      (operation),
        .char_code      (char_code),
        .attribute      (attribute),
        .column         (column),
        .row            (row),
        .done           (done),
        .cell_char      (cell_char),
        .cell_attribute (cell_attribute),
        .cursor_column  (cursor_column),
        .cursor_row     (cursor_row)
    );

endmodule

// ----- bench/text_console_cursor_scroll_checker.sv -----
`timescale 1ns / 100ps

module text_console_cursor_scroll_checker #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [tccs_pkg::OP_W-1:0]     operation,
    input  logic [tccs_pkg::BYTE_W-1:0]   char_code,
    input  logic [tccs_pkg::BYTE_W-1:0]   attribute,
    input  logic [tccs_pkg::COL_PW-1:0]   column,
    input  logic [tccs_pkg::ROW_PW-1:0]   row,
    input  logic                          done,
    input  logic [tccs_pkg::BYTE_W-1:0]   cell_char,
    input  logic [tccs_pkg::BYTE_W-1:0]   cell_attribute,
    input  logic [tccs_pkg::COL_PW-1:0]   cursor_column,
    input  logic [tccs_pkg::ROW_PW-1:0]   cursor_row,
    output int                            fail_count,
    output int                            outstanding
);

    import tccs_pkg::*;

    localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic [BYTE_W-1:0] attr;
        logic [COL_PW-1:0] col;
        logic [ROW_PW-1:0] line;
    } console_result_t;

    // attribute in the high byte, character in the low byte
    logic [CELL_W-1:0] screen_cells [0:CELLS-1];
    int                cur_col;
    int                cur_line;
    console_result_t   pending_results [$];

    task automatic console_step(
        input  op_t               op,
        input  logic [BYTE_W-1:0] ch,
        input  logic [BYTE_W-1:0] attr,
        input  logic [COL_PW-1:0] col,
        input  logic [ROW_PW-1:0] rw,
        output console_result_t   res
    );
        logic on_grid;
        on_grid = (col < SCREEN_COLUMNS) && (rw < SCREEN_ROWS);
        res.ch = '0;
        res.attr = '0;
        case (op)
            OP_PUT:
            begin
                // pending wrap is taken before anything else
                if (cur_col >= SCREEN_COLUMNS)
                begin
                    cur_col = 0;
                    cur_line++;
                end
                if (ch == NEWLINE_CODE)
                begin
                    cur_col = 0;
                    cur_line++;
                end
                if (cur_line >= SCREEN_ROWS)
                begin
                    for (int i = 0; i < SCREEN_COLUMNS * (SCREEN_ROWS - 1); i++)
                        screen_cells[i] = screen_cells[i + SCREEN_COLUMNS];
                    for (int i = SCREEN_COLUMNS * (SCREEN_ROWS - 1); i < CELLS; i++)
                        screen_cells[i] = {BLANK_ATTRIBUTE, 8'h00};
                    cur_line = SCREEN_ROWS - 1;
                end
                if (ch != NEWLINE_CODE)
                begin
                    screen_cells[cur_line * SCREEN_COLUMNS + cur_col] = {attr, ch};
                    cur_col++;
                end
            end
            OP_WRITE:
            begin
                if (on_grid)
                    screen_cells[rw * SCREEN_COLUMNS + col] = {attr, ch};
            end
            OP_CURSOR:
            begin
                cur_col = (col < SCREEN_COLUMNS) ? col : SCREEN_COLUMNS - 1;
                cur_line = (rw < SCREEN_ROWS) ? rw : SCREEN_ROWS - 1;
            end
            default:
            begin
                if (on_grid)
                    {res.attr, res.ch} = screen_cells[rw * SCREEN_COLUMNS + col];
            end
        endcase
        res.col = cur_col[COL_PW-1:0];
        res.line = cur_line[ROW_PW-1:0];
    endtask

    task automatic report_mismatch(input string field, input int want, input int got);
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        console_result_t want;
        console_result_t got;
        int bad;
        if (!rst_n)
        begin
            for (int i = 0; i < CELLS; i++)
                screen_cells[i] = '0;
            cur_col = 0;
            cur_line = 0;
            pending_results.delete();
            fail_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            bad = 0;
            if (done)
            begin
                got = {cell_char, cell_attribute, cursor_column, cursor_row};
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with no transaction outstanding: %h", $time, got);
                    bad++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.ch !== want.ch)
                    begin
                        report_mismatch("cell_char", want.ch, got.ch);
                        bad++;
                    end
                    if (got.attr !== want.attr)
                    begin
                        report_mismatch("cell_attribute", want.attr, got.attr);
                        bad++;
                    end
                    if (got.col !== want.col)
                    begin
                        report_mismatch("cursor_column", want.col, got.col);
                        bad++;
                    end
                    if (got.line !== want.line)
                    begin
                        report_mismatch("cursor_row", want.line, got.line);
                        bad++;
                    end
                end
            end
            if (start && !busy)
            begin
                console_step(op_t'(operation), char_code, attribute, column, row, want);
                pending_results.push_back(want);
            end
            if (bad != 0)
                fail_count <= fail_count + bad;
            outstanding <= pending_results.size();
        end
    end

endmodule

// ----- bench/text_console_cursor_scroll_tb.sv -----
`timescale 1ns / 100ps

module text_console_cursor_scroll_tb;

    import tccs_pkg::*;

    localparam int COLS       = 80;
    localparam int ROWS       = 25;
    // a scroll or the clearing sweep after reset sweeps every cell of the screen
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN      = 16;
    localparam int PHASE_LEN  = 137;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [OP_W-1:0]     operation = '0;
    logic [BYTE_W-1:0]   char_code = '0;
    logic [BYTE_W-1:0]   attribute = '0;
    logic [COL_PW-1:0]   column = '0;
    logic [ROW_PW-1:0]   row = '0;
    logic                busy;
    logic                done;
    logic [BYTE_W-1:0]   cell_char;
    logic [BYTE_W-1:0]   cell_attribute;
    logic [COL_PW-1:0]   cursor_column;
    logic [ROW_PW-1:0]   cursor_row;
    int                  fail_count;
    int                  outstanding;
    int                  idle_pct = 0;
    int                  quiet_cycles = 0;

    always #1 clk = ~clk;

    text_console_cursor_scroll #(
        .SCREEN_COLUMNS(COLS),
        .SCREEN_ROWS(ROWS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .char_code(char_code),
        .attribute(attribute),
        .column(column),
        .row(row),
        .done(done),
        .cell_char(cell_char),
        .cell_attribute(cell_attribute),
        .cursor_column(cursor_column),
        .cursor_row(cursor_row)
    );

    text_console_cursor_scroll_checker #(
        .SCREEN_COLUMNS(COLS),
        .SCREEN_ROWS(ROWS)
    ) i_checker (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .char_code(char_code),
        .attribute(attribute),
        .column(column),
        .row(row),
        .done(done),
        .cell_char(cell_char),
        .cell_attribute(cell_attribute),
        .cursor_column(cursor_column),
        .cursor_row(cursor_row),
        .fail_count(fail_count),
        .outstanding(outstanding)
    );

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // start stays high from one transaction to the next unless the sender idles
    task automatic send_item(
        input op_t               op,
        input logic [BYTE_W-1:0] ch,
        input logic [BYTE_W-1:0] attr,
        input logic [COL_PW-1:0] col,
        input logic [ROW_PW-1:0] rw
    );
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        operation <= op;
        char_code <= ch;
        attribute <= attr;
        column <= col;
        row <= rw;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic send_random();
        int pick;
        op_t op;
        logic [BYTE_W-1:0] ch;
        logic [BYTE_W-1:0] attr;
        logic [COL_PW-1:0] col;
        logic [ROW_PW-1:0] rw;
        pick = $urandom_range(99);
        ch = BYTE_W'($urandom_range(255));
        attr = BYTE_W'($urandom_range(255));
        if ($urandom_range(99) < 15)
        begin
            col = COL_PW'($urandom_range(127));
            rw = ROW_PW'($urandom_range(31));
        end
        else
        begin
            col = COL_PW'($urandom_range(COLS - 1));
            rw = ROW_PW'($urandom_range(ROWS - 1));
        end
        if (pick < 55)
        begin
            op = OP_PUT;
            if ($urandom_range(99) < 8)
                ch = NEWLINE_CODE;
        end
        else if (pick < 70)
            op = OP_WRITE;
        else if (pick < 80)
        begin
            op = OP_CURSOR;
            // park near the bottom right to provoke wraps and scrolls
            if ($urandom_range(99) < 40)
            begin
                col = COL_PW'($urandom_range(127, COLS - 4));
                rw = ROW_PW'($urandom_range(31, ROWS - 3));
            end
        end
        else
            op = OP_READ;
        send_item(op, ch, attr, col, rw);
    endtask

    initial
    begin : stimulus
        int pct [4];
        pct = '{0, 57, 13, 0};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_item(OP_READ,   8'h00, 8'h00, 7'd0,   5'd0);
        send_item(OP_PUT,    8'h41, 8'hFF, 7'd0,   5'd0);
        send_item(OP_READ,   8'h00, 8'h00, 7'd0,   5'd0);
        send_item(OP_WRITE,  8'hFF, 8'hFF, 7'd79,  5'd24);
        send_item(OP_READ,   8'h00, 8'h00, 7'd79,  5'd24);
        // out of grid: write ignored, reads give zero
        send_item(OP_WRITE,  8'h5A, 8'h33, 7'd80,  5'd0);
        send_item(OP_WRITE,  8'h5A, 8'h33, 7'd0,   5'd25);
        send_item(OP_READ,   8'h00, 8'h00, 7'd80,  5'd0);
        send_item(OP_READ,   8'h00, 8'h00, 7'd127, 5'd31);
        // saturating cursor, then fill the last cell: wrap pending
        send_item(OP_CURSOR, 8'h00, 8'h00, 7'd127, 5'd31);
        send_item(OP_PUT,    8'h78, 8'h1E, 7'd0,   5'd0);
        // newline while wrap pending at the bottom: scroll, blank row
        send_item(OP_PUT,    NEWLINE_CODE, 8'h00, 7'd0, 5'd0);
        send_item(OP_READ,   8'h00, 8'h00, 7'd79,  5'd23);
        send_item(OP_READ,   8'h00, 8'h00, 7'd0,   5'd24);
        // wrap at the bottom row scrolls before the write
        send_item(OP_CURSOR, 8'h00, 8'h00, 7'd78,  5'd24);
        send_item(OP_PUT,    8'h61, 8'h02, 7'd0,   5'd0);
        send_item(OP_PUT,    8'h62, 8'h03, 7'd0,   5'd0);
        send_item(OP_PUT,    8'h63, 8'h04, 7'd0,   5'd0);
        send_item(OP_READ,   8'h00, 8'h00, 7'd0,   5'd24);
        send_item(OP_READ,   8'h00, 8'h00, 7'd79,  5'd23);
        send_item(OP_CURSOR, 8'h00, 8'h00, 7'd0,   5'd0);
        send_item(OP_PUT,    NEWLINE_CODE, 8'hFF, 7'd0, 5'd0);
        send_item(OP_PUT,    8'h00, 8'h00, 7'd0,   5'd0);
        send_item(OP_PUT,    8'hFF, 8'h80, 7'd0,   5'd0);
        send_item(OP_READ,   8'h00, 8'h00, 7'd1,   5'd1);

        for (int p = 0; p < 4; p++)
        begin
            idle_pct = pct[p];
            repeat (PHASE_LEN) send_random();
        end
        start <= 1'b0;

        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN) @(posedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
